[hdl/ptd_pkg.sv]
// Shared codes and types for the prefix tree dictionary.
package ptd_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_PREFIX = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  localparam int LETTER_W = 5;

  typedef struct packed {
    logic clear;
    logic child_rd;
    logic child_wr;
    logic mark_rd;
    logic mark_wr;
  } ptd_mem_ctl_t;

endpackage

[hdl/ptd_store.sv]
// Child pointer memory and word end mark memory of the prefix tree.
module ptd_store #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26,
  localparam int NW = $clog2(NODE_COUNT),
  localparam int LW = $clog2(ALPHABET_SIZE)
) (
  input  logic                  clk,
  input  ptd_pkg::ptd_mem_ctl_t ctl,
  input  logic [NW-1:0]         node,
  input  logic [LW-1:0]         letter,
  input  logic [NW-1:0]         child_wdata,
  input  logic [NW-1:0]         mark_node,
  output logic [NW-1:0]         child_rdata,
  output logic                  mark_rdata
);
  import ptd_pkg::*;

  logic [NW-1:0] child_mem [NODE_COUNT][ALPHABET_SIZE];
  logic          mark_mem  [NODE_COUNT];

  // A clear wipes one child entry of the node and the node's mark.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      child_mem[node][letter] <= '0;
    end else if (ctl.child_wr) begin
      child_mem[node][letter] <= child_wdata;
    end
    if (ctl.child_rd) begin
      child_rdata <= child_mem[node][letter];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      mark_mem[node] <= 1'b0;
    end else if (ctl.mark_wr) begin
      mark_mem[mark_node] <= 1'b1;
    end
    if (ctl.mark_rd) begin
      mark_rdata <= mark_mem[mark_node];
    end
  end

endmodule

[hdl/prefix_tree_dictionary_core.sv]
// Top level of the prefix tree dictionary: walk sequencer and result register.
// Words come in one letter per input word, the final one flagged by last, and
// each final word yields one status word (0 done or found, 1 not found, 2 node
// pool full). After reset the block sweeps both memories one child entry per
// cycle with in_ready low. A lettered word that walks reads the child memory,
// then, if it is the final word of the entry, the word end mark; a final word
// with no letter, or one after the walk has stopped, reads only the word end
// mark; any other word needs no memory read. The next word is taken while a
// result waits on the output.
module prefix_tree_dictionary_core #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [4:0] letter,
  input  logic       has_letter,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status
);
  import ptd_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int LW = $clog2(ALPHABET_SIZE);
  localparam int XW = (LW > LETTER_W) ? LW : LETTER_W;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [NW-1:0] clr_idx, clr_idx_next;
  logic [LW-1:0] clr_letter, clr_letter_next;
  logic [NW-1:0] cursor, cursor_next;
  logic [NW:0]   free_count, free_count_next;
  logic          walk_failed, walk_failed_next;
  logic          pool_over, pool_over_next;
  logic [1:0]    kind_q, kind_q_next;
  logic          last_q, last_q_next;
  logic [LW-1:0] letter_q, letter_q_next;
  logic          out_valid_next;
  logic [1:0]    status_next;

  ptd_mem_ctl_t  ctl;
  logic [NW-1:0] mem_node;
  logic [LW-1:0] mem_letter;
  logic [NW-1:0] mark_node;
  logic [NW-1:0] child_rdata;
  logic          mark_rdata;

  logic [XW-1:0] letter_ext;
  logic [LW-1:0] letter_idx;
  logic          letter_ok;
  logic          accept;
  logic          stopped;
  logic          out_free;

  assign letter_ext = XW'(letter);
  assign letter_idx = letter_ext[LW-1:0];
  assign letter_ok  = 32'(letter) < ALPHABET_SIZE;
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign stopped    = walk_failed || pool_over;
  assign out_free   = !out_valid || out_ready;

  ptd_store #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_store (
    .clk         (clk),
    .ctl         (ctl),
    .node        (mem_node),
    .letter      (mem_letter),
    .child_wdata (free_count[NW-1:0]),
    .mark_node   (mark_node),
    .child_rdata (child_rdata),
    .mark_rdata  (mark_rdata)
  );

  // Reads are issued from IDLE and WALK, writes land in CLEAR, WALK and DONE,
  // so the sequencing alone keeps a read from overlapping a write to the same entry.
  always_comb begin
    state_next       = state;
    clr_idx_next     = clr_idx;
    clr_letter_next  = clr_letter;
    cursor_next      = cursor;
    free_count_next  = free_count;
    walk_failed_next = walk_failed;
    pool_over_next   = pool_over;
    kind_q_next      = kind_q;
    last_q_next      = last_q;
    letter_q_next    = letter_q;
    out_valid_next   = out_valid && !out_ready;
    status_next      = status;
    ctl              = '0;
    mem_node         = cursor;
    mem_letter       = letter_q;
    mark_node        = cursor;

    unique case (state)
      S_CLEAR: begin
        ctl.clear  = 1'b1;
        mem_node   = clr_idx;
        mem_letter = clr_letter;
        if (clr_letter == LW'(ALPHABET_SIZE - 1)) begin
          clr_letter_next = '0;
          clr_idx_next    = clr_idx + 1'b1;
          if (clr_idx == NW'(NODE_COUNT - 1)) begin
            state_next = S_IDLE;
          end
        end else begin
          clr_letter_next = clr_letter + 1'b1;
        end
      end
      S_IDLE: begin
        mem_letter = letter_idx;
        if (accept) begin
          kind_q_next   = kind;
          last_q_next   = last;
          letter_q_next = letter_idx;
          if (has_letter && !stopped && letter_ok) begin
            ctl.child_rd = 1'b1;
            state_next   = S_WALK;
          end else begin
            if (has_letter && !stopped) begin
              walk_failed_next = 1'b1;
            end
            if (last) begin
              ctl.mark_rd = 1'b1;
              state_next  = S_DONE;
            end
          end
        end
      end
      S_WALK: begin
        if (child_rdata != '0) begin
          cursor_next = child_rdata;
        end else if (kind_q != KIND_INSERT) begin
          walk_failed_next = 1'b1;
        end else if (free_count == (NW+1)'(NODE_COUNT)) begin
          pool_over_next = 1'b1;
        end else begin
          // Take the next fresh node and link it under the cursor.
          ctl.child_wr    = 1'b1;
          cursor_next     = free_count[NW-1:0];
          free_count_next = free_count + 1'b1;
        end
        if (last_q) begin
          ctl.mark_rd = 1'b1;
          mark_node   = cursor_next;
          state_next  = S_DONE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        // Hold until the output register can take the result.
        if (out_free) begin
          out_valid_next = 1'b1;
          if (pool_over) begin
            status_next = STATUS_FULL;
          end else if (walk_failed) begin
            status_next = STATUS_MISS;
          end else if (kind_q == KIND_INSERT) begin
            ctl.mark_wr = 1'b1;
            status_next = STATUS_OK;
          end else if (kind_q == KIND_SEARCH) begin
            status_next = mark_rdata ? STATUS_OK : STATUS_MISS;
          end else begin
            status_next = STATUS_OK;
          end
          cursor_next      = '0;
          walk_failed_next = 1'b0;
          pool_over_next   = 1'b0;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      clr_letter  <= '0;
      cursor      <= '0;
      free_count  <= (NW+1)'(1);
      walk_failed <= 1'b0;
      pool_over   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clr_idx     <= clr_idx_next;
      clr_letter  <= clr_letter_next;
      cursor      <= cursor_next;
      free_count  <= free_count_next;
      walk_failed <= walk_failed_next;
      pool_over   <= pool_over_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_q   <= kind_q_next;
    last_q   <= last_q_next;
    letter_q <= letter_q_next;
    status   <= status_next;
  end

endmodule

[hdl/ptd_checker.sv]
// Port-level checks for the prefix tree dictionary, bound to the top level.
module ptd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status
);
  import ptd_pkg::*;

  // The memory sweep after reset keeps the input closed.
  a_sweep_blocks_input: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("input open or result shown right after reset");

  // Only the three status codes are ever produced.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK || status == STATUS_MISS || status == STATUS_FULL))
    else $error("undefined status code on output");

  // A word that is not final cannot raise a result in the next cycle.
  a_no_result_mid_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last) |=> !$rose(out_valid))
    else $error("result raised after a word that was not final");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status)))
    else $error("stalled result dropped or changed");

endmodule

bind prefix_tree_dictionary_core ptd_checker u_ptd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .last      (last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status)
);
